// ----- rtl/ivfa_pkg.sv -----
`default_nettype none
package ivfa_pkg;

   localparam int unsigned TimeWidth = 47;
   localparam int unsigned RelWidth  = 48;
   localparam int unsigned VecWidth  = 32;
   localparam int unsigned QuatWidth = 16;
   localparam int unsigned MatWidth  = 32;
   // numerator magnitude fits in 34 bits, shifted by 30
   localparam int unsigned DivWidth  = 64;
   localparam int unsigned SumWidth  = 34;
   localparam logic [MatWidth-1:0] Q30One = 32'h4000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CROSS,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MAC,
      ST_MAC_WAIT,
      ST_ROUND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/ivfa_divider.sv -----
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle, rounds half up
// on the magnitude: q = (n + d/2) / d.
module ivfa_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ivfa_pkg::DivWidth-1:0] numer,
   input  wire logic [ivfa_pkg::SumWidth-1:0] denom,
   output ivfa_pkg::div_ctrl_type             ctrl,
   output logic      [ivfa_pkg::DivWidth-1:0] quot
);
   localparam int unsigned RemW = ivfa_pkg::SumWidth + 1;
   localparam int unsigned CntW = $clog2(ivfa_pkg::DivWidth + 1);

   logic [ivfa_pkg::DivWidth-1:0] n_ff, n_in;
   logic [RemW-1:0]               r_ff, r_in;
   logic [ivfa_pkg::SumWidth-1:0] d_ff, d_in;
   logic [CntW-1:0]               cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [RemW-1:0]               trial;
   logic [RemW-1:0]               diff;

   // one shift-subtract step
   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[RemW-2:0], n_ff[ivfa_pkg::DivWidth-1]};
      diff    = trial - {1'b0, d_ff};
      if (start) begin
         n_in    = numer + {{(ivfa_pkg::DivWidth-ivfa_pkg::SumWidth+1){1'b0}},
                            denom[ivfa_pkg::SumWidth-1:1]};
         d_in    = denom;
         r_in    = '0;
         cnt_in  = CntW'(ivfa_pkg::DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[RemW-1]) begin
            r_in = diff;
            n_in = {n_ff[ivfa_pkg::DivWidth-2:0], 1'b1};
         end else begin
            r_in = trial;
            n_in = {n_ff[ivfa_pkg::DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign quot       = n_ff;
endmodule
`default_nettype wire

// ----- rtl/imu_vision_frame_align.sv -----
`default_nettype none
// Frame alignment for inertial and camera words.
// Input channel req_*: valid/stall; one word at a time, req_stall is high
// while a word is being worked on. Result channel rsp_*: valid/stall, an
// output register holds the result until taken. csr_* writes time_offset.
// Camera word with a new x: the ten quaternion products are formed one per
// cycle on the shared 32x32 multiplier, then nine elements go one after
// another through the bit-serial divider, then the output step loads the
// result; the next word is taken only after it loads.
// Zero-length quaternion: no divisions, the matrix is left as it was.
// Camera word with a repeated x: no result, the next word can follow in
// the next cycle.
// Inertial word: nine 32x32 products on the shared multiplier, one per
// cycle within a row; each row is rounded as it ends, then the result loads.
// Rate is set by the shared multiplier and the one divider. Reset restores
// the identity matrix, last x 0, offset 0. While rsp_stall is high the
// result holds; a newer result waits in the last step with req_stall high.
module imu_vision_frame_align #(
   parameter int unsigned TimeW = ivfa_pkg::TimeWidth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_type,
   input  wire logic [TimeW-1:0]     req_time_stamp,
   input  wire logic signed [31:0]   req_vec_x,
   input  wire logic signed [31:0]   req_vec_y,
   input  wire logic signed [31:0]   req_vec_z,
   input  wire logic signed [15:0]   req_quat_w,
   input  wire logic signed [15:0]   req_quat_x,
   input  wire logic signed [15:0]   req_quat_y,
   input  wire logic signed [15:0]   req_quat_z,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_sensor_kind,
   output logic signed [TimeW:0]     rsp_rel_time,
   output logic signed [31:0]        rsp_out_x,
   output logic signed [31:0]        rsp_out_y,
   output logic signed [31:0]        rsp_out_z,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [TimeW-1:0]     csr_time_offset
);
   ivfa_pkg::state_type state_ff, state_in;

   logic [TimeW-1:0]        offset_ff;
   logic signed [31:0]      mat_ff [9];
   logic signed [31:0]      last_x_ff;
   logic                    kind_ff;
   logic [TimeW-1:0]        ts_ff;
   logic signed [31:0]      v_ff [3];
   logic signed [15:0]      q_ff [4];
   logic [3:0]              step_ff, step_in;
   logic signed [33:0]      prod_q_ff [10];
   logic signed [63:0]      acc_ff, acc_in;
   logic signed [31:0]      res_ff [3];
   logic                    out_v_ff;
   logic                    out_kind_ff;
   logic signed [TimeW:0]   out_t_ff;
   logic signed [31:0]      out_ff [3];

   // shared multiplier: 32x32 signed
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic accept, fresh;
   assign accept = req_valid && !req_stall;
   assign fresh  = req_vec_x != last_x_ff;

   // column of the matrix element in the multiply steps
   logic [1:0] col;
   always_comb begin
      unique case (step_ff)
         4'd0, 4'd3, 4'd6: col = 2'd0;
         4'd1, 4'd4, 4'd7: col = 2'd1;
         default:          col = 2'd2;
      endcase
   end

   // row that has just finished accumulating
   logic [1:0] row_done;
   always_comb begin
      unique case (step_ff)
         4'd3:    row_done = 2'd0;
         4'd6:    row_done = 2'd1;
         default: row_done = 2'd2;
      endcase
   end

   // quaternion products: ww xx yy zz xy zw xz yw yz xw
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ivfa_pkg::ST_SQUARE || state_ff == ivfa_pkg::ST_CROSS) begin
         unique case (step_ff)
            4'd0: begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[0]); end
            4'd1: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[1]); end
            4'd2: begin mul_a = 32'(q_ff[2]); mul_b = 32'(q_ff[2]); end
            4'd3: begin mul_a = 32'(q_ff[3]); mul_b = 32'(q_ff[3]); end
            4'd4: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[2]); end
            4'd5: begin mul_a = 32'(q_ff[3]); mul_b = 32'(q_ff[0]); end
            4'd6: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[3]); end
            4'd7: begin mul_a = 32'(q_ff[2]); mul_b = 32'(q_ff[0]); end
            4'd8: begin mul_a = 32'(q_ff[2]); mul_b = 32'(q_ff[3]); end
            default: begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[0]); end
         endcase
      end else if (state_ff == ivfa_pkg::ST_MAC) begin
         mul_a = mat_ff[step_ff];
         mul_b = v_ff[col];
      end
   end

   // element numerators from the stored products
   logic signed [33:0] s_sum;
   logic signed [34:0] numer;
   assign s_sum = prod_q_ff[0] + prod_q_ff[1] + prod_q_ff[2] + prod_q_ff[3];
   always_comb begin
      unique case (step_ff)
         4'd0: numer = 35'(prod_q_ff[1] - prod_q_ff[2] - prod_q_ff[3] + prod_q_ff[0]);
         4'd4: numer = 35'(-prod_q_ff[1] + prod_q_ff[2] - prod_q_ff[3] + prod_q_ff[0]);
         4'd8: numer = 35'(-prod_q_ff[1] - prod_q_ff[2] + prod_q_ff[3] + prod_q_ff[0]);
         4'd3: numer = 35'((prod_q_ff[4] + prod_q_ff[5]) <<< 1);
         4'd1: numer = 35'((prod_q_ff[4] - prod_q_ff[5]) <<< 1);
         4'd6: numer = 35'((prod_q_ff[6] - prod_q_ff[7]) <<< 1);
         4'd2: numer = 35'((prod_q_ff[6] + prod_q_ff[7]) <<< 1);
         4'd7: numer = 35'((prod_q_ff[8] + prod_q_ff[9]) <<< 1);
         default: numer = 35'((prod_q_ff[8] - prod_q_ff[9]) <<< 1);
      endcase
   end

   logic        numer_neg;
   logic [33:0] numer_mag;
   assign numer_neg = numer[34];
   assign numer_mag = numer_neg ? 34'(-numer) : numer[33:0];

   ivfa_pkg::div_ctrl_type div_ctrl;
   logic [63:0]            quot;
   logic                   neg_ff;
   ivfa_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ivfa_pkg::ST_DIV_START),
      .numer ({numer_mag, 30'd0}),
      .denom (s_sum),
      .ctrl  (div_ctrl),
      .quot  (quot)
   );

   // round and saturate a Q18.46 sum
   logic signed [63:0] rnd;
   logic signed [33:0] shifted;
   logic signed [31:0] sat;
   assign rnd     = acc_ff + 64'sd536870912;
   assign shifted = 34'(rnd >>> 30);
   assign sat = (shifted > 34'sd2147483647) ? 32'sh7fffffff :
                (shifted < -34'sd2147483648) ? 32'sh80000000 : shifted[31:0];

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ivfa_pkg::ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               if (!req_type) state_in = ivfa_pkg::ST_MAC;
               else if (fresh) state_in = ivfa_pkg::ST_SQUARE;
            end
         end
         ivfa_pkg::ST_SQUARE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd3) state_in = ivfa_pkg::ST_CROSS;
         end
         ivfa_pkg::ST_CROSS: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd9) begin
               step_in  = '0;
               state_in = ivfa_pkg::ST_DIV_START;
            end
         end
         ivfa_pkg::ST_DIV_START: begin
            if (s_sum == '0) state_in = ivfa_pkg::ST_OUT;
            else state_in = ivfa_pkg::ST_DIV_WAIT;
         end
         ivfa_pkg::ST_DIV_WAIT: begin
            if (div_ctrl.done) begin
               step_in  = step_ff + 1'b1;
               state_in = (step_ff == 4'd8) ? ivfa_pkg::ST_OUT : ivfa_pkg::ST_DIV_START;
            end
         end
         ivfa_pkg::ST_MAC: begin
            step_in = step_ff + 1'b1;
            if (col == 2'd2) state_in = ivfa_pkg::ST_MAC_WAIT;
         end
         ivfa_pkg::ST_MAC_WAIT: begin
            state_in = (step_ff == 4'd9) ? ivfa_pkg::ST_ROUND : ivfa_pkg::ST_MAC;
         end
         ivfa_pkg::ST_ROUND: state_in = ivfa_pkg::ST_OUT;
         ivfa_pkg::ST_OUT: if (!out_v_ff || !rsp_stall) state_in = ivfa_pkg::ST_IDLE;
         default: state_in = ivfa_pkg::ST_IDLE;
      endcase
   end

   // accumulator for one matrix row
   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ivfa_pkg::ST_MAC) begin
         acc_in = (col == 2'd0) ? mul_p : acc_ff + mul_p;
      end
   end

   assign req_stall = (state_ff != ivfa_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ivfa_pkg::ST_IDLE;
         step_ff   <= '0;
         offset_ff <= '0;
         last_x_ff <= '0;
         out_v_ff  <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= (i % 4 == 0) ? ivfa_pkg::Q30One : '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_valid) offset_ff <= csr_time_offset;
         if (accept && req_type) last_x_ff <= req_vec_x;
         // write one element when its quotient is done
         if (state_ff == ivfa_pkg::ST_DIV_WAIT && div_ctrl.done) begin
            mat_ff[step_ff] <= neg_ff ? -quot[31:0] : quot[31:0];
         end
         // load a new result, or drop the old one once taken
         if (state_ff == ivfa_pkg::ST_OUT && (!out_v_ff || !rsp_stall)) out_v_ff <= 1'b1;
         else if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
      end
      if (accept) begin
         kind_ff <= req_type;
         ts_ff   <= req_time_stamp;
         v_ff[0] <= req_vec_x;
         v_ff[1] <= req_vec_y;
         v_ff[2] <= req_vec_z;
         q_ff[0] <= req_quat_w;
         q_ff[1] <= req_quat_x;
         q_ff[2] <= req_quat_y;
         q_ff[3] <= req_quat_z;
      end
      if (state_ff == ivfa_pkg::ST_SQUARE || state_ff == ivfa_pkg::ST_CROSS) begin
         prod_q_ff[step_ff] <= mul_p[33:0];
      end
      if (state_ff == ivfa_pkg::ST_DIV_START) neg_ff <= numer_neg;
      acc_ff <= acc_in;
      if (state_ff == ivfa_pkg::ST_MAC_WAIT) res_ff[row_done] <= sat;
      if (state_ff == ivfa_pkg::ST_OUT && (!out_v_ff || !rsp_stall)) begin
         out_kind_ff <= kind_ff;
         out_t_ff    <= {1'b0, ts_ff} - {1'b0, offset_ff};
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= kind_ff ? v_ff[i] : res_ff[i];
         end
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_sensor_kind = out_kind_ff;
   assign rsp_rel_time    = out_t_ff;
   assign rsp_out_x       = out_ff[0];
   assign rsp_out_y       = out_ff[1];
   assign rsp_out_z       = out_ff[2];
endmodule
`default_nettype wire

// ----- rtl/ivfa_checker.sv -----
`default_nettype none
module ivfa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic req_type,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_sensor_kind,
   input wire logic [31:0] rsp_out_x
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x))
      else $error("result changed under stall");

   // an accepted inertial word makes the block busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_type |=> req_stall)
      else $error("accepted word without busy");

   // a new result shows up only after the block was busy
   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a word in work");

   // result kind stable under stall
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sensor_kind))
      else $error("result kind changed under stall");
endmodule

bind imu_vision_frame_align ivfa_checker u_ivfa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_sensor_kind (rsp_sensor_kind),
   .rsp_out_x       (rsp_out_x)
);
`default_nettype wire
